// ===== hw/rtl/hti_pkg.sv =====
`timescale 1ns / 1ps

package hti_pkg;

   localparam int ZOOM_W  = 5;
   localparam int COORD_W = 31;
   localparam int IDX_W   = 2 * COORD_W;
   localparam int ID_W    = 63;

   typedef struct packed {
      logic [ZOOM_W-1:0]  zoom;
      logic [COORD_W-1:0] tile_col;
      logic [COORD_W-1:0] tile_row;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] tile_id;
      logic            coord_error;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic               err;
      logic [ZOOM_W-1:0]  zoom;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [IDX_W-1:0]   idx;
   } stage_type;

endpackage

// ===== hw/rtl/hti_cell.sv =====
`timescale 1ns / 1ps

module hti_cell #(
   parameter int LEVEL = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  hti_pkg::stage_type   stage_i,
   output hti_pkg::stage_type   stage_o
);

   localparam logic [hti_pkg::ZOOM_W-1:0] LVL = hti_pkg::ZOOM_W'(LEVEL);

   hti_pkg::stage_type stage_ff;
   hti_pkg::stage_type stage_in;
   logic               active;
   logic               rx;
   logic               ry;
   logic [hti_pkg::COORD_W-1:0] flip;

   always_comb begin
      stage_in = stage_i;
      active   = stage_i.zoom > LVL;
      rx       = stage_i.x[LEVEL];
      ry       = stage_i.y[LEVEL];
      flip     = {hti_pkg::COORD_W{rx}};
      if (active) begin
         stage_in.idx[2*LEVEL+1] = rx;
         stage_in.idx[2*LEVEL]   = rx ^ ry;
         if (!ry) begin
            stage_in.x = stage_i.y ^ flip;
            stage_in.y = stage_i.x ^ flip;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

// ===== hw/rtl/hti_out.sv =====
`timescale 1ns / 1ps

module hti_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  hti_pkg::stage_type stage_i,
   output logic               rsp_valid,
   output hti_pkg::rsp_type   rsp_data
);

   logic             rsp_valid_ff;
   hti_pkg::rsp_type rsp_data_ff;
   hti_pkg::rsp_type rsp_data_in;
   logic [hti_pkg::ID_W-1:0] base;

   always_comb begin
      base = '0;
      for (int k = 0; k < hti_pkg::COORD_W; k++) begin
         base[2*k] = stage_i.zoom > hti_pkg::ZOOM_W'(k);
      end
      rsp_data_in.coord_error = stage_i.err;
      if (stage_i.err) begin
         rsp_data_in.tile_id = '0;
      end else begin
         rsp_data_in.tile_id = base + hti_pkg::ID_W'(stage_i.idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stage_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/hilbert_tile_id_unit.sv =====
`timescale 1ns / 1ps

// Maps a tile (zoom, column, row) to its tile id: the count of all tiles on
// lower zooms plus the tile's position on the Hilbert curve of its zoom.
// A chain of MAX_ZOOM cells resolves one coordinate level each, top level
// first, and a final registered stage adds the zoom base. A new transaction
// can enter in every cycle; a stalled result holds the whole chain, so the
// request side stalls exactly while a result is stalled. A zoom above
// MAX_ZOOM or a coordinate not below 2^zoom yields coord_error with id 0.
module hilbert_tile_id_unit #(
   parameter int MAX_ZOOM = 31
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hti_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hti_pkg::rsp_type rsp_data
);

   localparam logic [hti_pkg::ZOOM_W-1:0] ZOOM_LIMIT = hti_pkg::ZOOM_W'(MAX_ZOOM);

   hti_pkg::stage_type stage_w [MAX_ZOOM+1];
   logic               advance;
   logic               range_err;

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      range_err = (req_data.zoom > ZOOM_LIMIT)
                  || ((req_data.tile_col >> req_data.zoom) != '0)
                  || ((req_data.tile_row >> req_data.zoom) != '0);
      stage_w[0].valid = req_valid;
      stage_w[0].err   = range_err;
      stage_w[0].zoom  = req_data.zoom;
      stage_w[0].x     = req_data.tile_col;
      stage_w[0].y     = req_data.tile_row;
      stage_w[0].idx   = '0;
   end

   for (genvar i = 0; i < MAX_ZOOM; i++) begin : g_cell
      hti_cell #(
         .LEVEL(MAX_ZOOM - 1 - i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .stage_i (stage_w[i]),
         .stage_o (stage_w[i+1])
      );
   end

   hti_out u_out (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .stage_i   (stage_w[MAX_ZOOM]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // A rejected transaction always carries a zero id.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.coord_error |-> rsp_data.tile_id == '0)
      else $error("error result with nonzero tile id");

   // While a result is held, the last cell keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(stage_w[MAX_ZOOM]))
      else $error("chain moved while result stalled");

   // A transaction that leaves the chain without error has a legal zoom.
   assert property (@(posedge clock) disable iff (reset)
      stage_w[MAX_ZOOM].valid && !stage_w[MAX_ZOOM].err
      |-> stage_w[MAX_ZOOM].zoom <= ZOOM_LIMIT)
      else $error("accepted zoom above limit");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int MAX_ZOOM   = 31;
   localparam int LATENCY    = MAX_ZOOM + 1;
   localparam int IDLE_LIMIT = 4000;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   hti_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   hti_pkg::rsp_type rsp_data;

   hti_pkg::rsp_type tile_id_q[$];
   int               mismatches = 0;
   int               quiet_cycles = 0;
   bit               no_idle = 1'b0;

   hilbert_tile_id_unit #(
      .MAX_ZOOM (MAX_ZOOM)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   function automatic hti_pkg::rsp_type predict_tile_id(hti_pkg::req_type item);
      logic [63:0]      acc;
      logic [63:0]      x;
      logic [63:0]      y;
      logic [63:0]      low;
      logic [63:0]      rx;
      logic [63:0]      ry;
      logic [63:0]      t;
      int               z;
      int               lvl;
      hti_pkg::rsp_type p;
      z = item.zoom;
      x = item.tile_col;
      y = item.tile_row;
      p = '0;
      if (z > MAX_ZOOM || x >= (64'd1 << z) || y >= (64'd1 << z)) begin
         p.coord_error = 1'b1;
         return p;
      end
      acc = ((64'd1 << (2 * z)) - 64'd1) / 64'd3;
      for (lvl = z - 1; lvl >= 0; lvl--) begin
         low = (64'd1 << lvl) - 64'd1;
         rx  = (x >> lvl) & 64'd1;
         ry  = (y >> lvl) & 64'd1;
         acc = acc + (((64'd3 * rx) ^ ry) << (2 * lvl));
         x   = x & low;
         y   = y & low;
         if (ry == 64'd0) begin
            if (rx != 64'd0) begin
               x = x ^ low;
               y = y ^ low;
            end
            t = x;
            x = y;
            y = t;
         end
      end
      p.tile_id = acc[hti_pkg::ID_W-1:0];
      return p;
   endfunction

   task automatic send_tile(input logic [hti_pkg::ZOOM_W-1:0] z,
                            input logic [hti_pkg::COORD_W-1:0] col,
                            input logic [hti_pkg::COORD_W-1:0] row);
      hti_pkg::req_type item;
      item.zoom     = z;
      item.tile_col = col;
      item.tile_row = row;
      @(negedge clock);
      if (!no_idle) begin
         while ($urandom_range(0, 99) < 26) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      tile_id_q.insert(tile_id_q.size(), predict_tile_id(item));
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tile_id_q.size() != 0) @(negedge clock);
   endtask

   task automatic test_zoom_zero();
      send_tile(5'd0, 31'd0, 31'd0);
      send_tile(5'd0, 31'd1, 31'd0);
      send_tile(5'd0, 31'd0, 31'd1);
   endtask

   task automatic test_boundaries();
      send_tile(5'd1, 31'd0, 31'd0);
      send_tile(5'd1, 31'd1, 31'd0);
      send_tile(5'd1, 31'd0, 31'd1);
      send_tile(5'd1, 31'd1, 31'd1);
      send_tile(5'd31, 31'd0, 31'd0);
      send_tile(5'd31, '1, '1);
      send_tile(5'd31, '1, 31'd0);
      send_tile(5'd31, 31'd0, '1);
      send_tile(5'd30, 31'h3FFF_FFFF, 31'h3FFF_FFFF);
      send_tile(5'd2, 31'd3, 31'd0);
   endtask

   task automatic test_out_of_range();
      send_tile(5'd30, 31'h4000_0000, 31'd0);
      send_tile(5'd30, 31'd0, 31'h4000_0000);
      send_tile(5'd5, 31'd32, 31'd32);
      send_tile(5'd1, 31'd2, 31'd0);
      send_tile(5'd0, '1, '1);
      send_tile(5'd16, 31'd0, '1);
   endtask

   task automatic test_random_tiles(input int count);
      logic [hti_pkg::ZOOM_W-1:0]  z;
      logic [hti_pkg::COORD_W-1:0] mask;
      logic [hti_pkg::COORD_W-1:0] col;
      logic [hti_pkg::COORD_W-1:0] row;
      int                          kind;
      for (int i = 0; i < count; i++) begin
         z    = hti_pkg::ZOOM_W'($urandom_range(0, MAX_ZOOM));
         mask = (z == 5'd31) ? '1 : ((31'd1 << z) - 31'd1);
         kind = $urandom_range(0, 99);
         col  = hti_pkg::COORD_W'($urandom) & mask;
         row  = hti_pkg::COORD_W'($urandom) & mask;
         if (kind < 8) begin
            col = mask;
         end else if (kind < 14) begin
            row = mask;
         end else if (kind < 20) begin
            col = hti_pkg::COORD_W'($urandom);
            row = hti_pkg::COORD_W'($urandom);
         end else if (kind < 24 && z != 5'd31) begin
            col = mask + 31'd1;
         end else if (kind < 28 && z != 5'd31) begin
            row = mask + 31'd1 + (hti_pkg::COORD_W'($urandom) & mask);
         end
         send_tile(z, col, row);
      end
   endtask

   task automatic test_drain_pause();
      drain_results();
      test_random_tiles(20);
   endtask

   always @(negedge clock) begin
      rsp_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 26);
   end

   always @(posedge clock) begin
      hti_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tile_id_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected transaction, actual id %0d error %0b", $time,
                     rsp_data.tile_id, rsp_data.coord_error);
         end else begin
            want = tile_id_q.pop_front();
            if (rsp_data.tile_id !== want.tile_id) begin
               mismatches++;
               $display("%0t: tile_id expected %0d actual %0d", $time, want.tile_id,
                        rsp_data.tile_id);
            end
            if (rsp_data.coord_error !== want.coord_error) begin
               mismatches++;
               $display("%0t: coord_error expected %0b actual %0b", $time,
                        want.coord_error, rsp_data.coord_error);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_zoom_zero();
      test_boundaries();
      test_out_of_range();
      no_idle = 1'b1;
      test_random_tiles(400);
      no_idle = 1'b0;
      test_random_tiles(350);
      test_drain_pause();
      test_random_tiles(380);
      drain_results();
      repeat (LATENCY + 4) @(negedge clock);
      if (mismatches == 0 && tile_id_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== hilbert_tile_id_unit.f =====
hw/rtl/hti_pkg.sv
hw/rtl/hti_cell.sv
hw/rtl/hti_out.sv
hw/rtl/hilbert_tile_id_unit.sv
test/tb_top.sv
